>>> src/lwoa_pkg.sv
// Shared types and constants for the long-window region overlap-add unit.
`default_nettype none
package lwoa_pkg;

  localparam int MaxFrame   = 2048;
  localparam int PosW       = $clog2(MaxFrame);
  localparam int LenW       = PosW + 1;
  localparam int CfgW       = 12;
  localparam int CmpW       = ((LenW > CfgW) ? LenW : CfgW) + 1;
  localparam int QW         = 5;
  localparam int DataW      = 32;
  localparam int ProdW      = 2 * DataW;
  localparam int QFrac      = 31;
  localparam int CfgIdxW    = 3;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [CfgW-1:0] FrameLenRst = CfgW'(1024);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FLAT_LEN  = 3'd0,
    CFG_TRANS_LEN = 3'd1,
    CFG_FRAME_LEN = 3'd2,
    CFG_CUR_Q     = 3'd3,
    CFG_OVL_Q     = 3'd4
  } lwoa_cfg_idx_e;

  typedef enum logic [1:0] {
    RGN_FLAT = 2'd0,
    RGN_RISE = 2'd1,
    RGN_FALL = 2'd2,
    RGN_TAIL = 2'd3
  } lwoa_region_e;

  typedef struct packed {
    logic signed [DataW-1:0] frame_sample;
    logic signed [DataW-1:0] overlap_sample;
    logic signed [DataW-1:0] forward_coef;
    logic signed [DataW-1:0] reverse_coef;
  } lwoa_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] out_sample;
    logic        [QW-1:0]    out_q;
    logic                    frame_end;
  } lwoa_out_t;

  // Classified word handed from the front to the back through the queue.
  typedef struct packed {
    lwoa_region_e            region;
    logic signed [DataW-1:0] op_a;      // frame sample, negated where the region asks
    logic signed [DataW-1:0] ovl;
    logic signed [DataW-1:0] fwd;
    logic signed [DataW-1:0] rev;
    logic        [QW-1:0]    sh;        // right shift applied to the finer term
    logic                    cur_finer;
    logic        [QW-1:0]    oq;
    logic                    frame_end;
  } lwoa_job_t;

endpackage
`default_nettype wire

>>> src/lwoa_front.sv
// Front end: config registers, position counter and region classification.
`default_nettype none
module lwoa_front (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cfg_valid_i,
  input  wire [lwoa_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire [lwoa_pkg::CfgW-1:0]   cfg_data_i,
  input  wire                        in_valid_i,
  input  wire lwoa_pkg::lwoa_in_t    in_data_i,
  input  wire                        q_ready_i,
  output logic                       q_push_o,
  output lwoa_pkg::lwoa_job_t        q_job_o
);
  import lwoa_pkg::*;

  logic [CfgW-1:0] flat_len_q, trans_len_q, frame_len_q;
  logic [QW-1:0]   cur_q_q, ovl_q_q;
  logic [PosW-1:0] pos_q, pos_d;

  logic [CmpW-1:0] len_raw, len_eff, half, trans_end, tail_start, pos_ext, flat_ext;
  logic            last, finer;
  logic [QW-1:0]   dq;
  lwoa_region_e    region;
  logic [DataW-1:0] neg_frame;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flat_len_q  <= '0;
      trans_len_q <= '0;
      frame_len_q <= FrameLenRst;
      cur_q_q     <= '0;
      ovl_q_q     <= '0;
    end else if (cfg_valid_i) begin
      case (lwoa_cfg_idx_e'(cfg_index_i))
        CFG_FLAT_LEN:  flat_len_q  <= cfg_data_i;
        CFG_TRANS_LEN: trans_len_q <= cfg_data_i;
        CFG_FRAME_LEN: frame_len_q <= cfg_data_i;
        CFG_CUR_Q:     cur_q_q     <= cfg_data_i[QW-1:0];
        CFG_OVL_Q:     ovl_q_q     <= cfg_data_i[QW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len_raw = CmpW'(frame_len_q);
    if (len_raw > CmpW'(MaxFrame)) begin
      len_eff = CmpW'(MaxFrame);
    end else if (len_raw == '0) begin
      len_eff = CmpW'(1);
    end else begin
      len_eff = len_raw;
    end
    half       = len_eff >> 1;
    trans_end  = CmpW'(flat_len_q) + CmpW'(trans_len_q);
    tail_start = (trans_end > half) ? trans_end : half;
    pos_ext    = CmpW'(pos_q);
    flat_ext   = CmpW'(flat_len_q);

    if (pos_ext >= tail_start) begin
      region = RGN_TAIL;
    end else if (pos_ext >= half) begin
      region = RGN_FALL;
    end else if (pos_ext >= flat_ext) begin
      region = RGN_RISE;
    end else begin
      region = RGN_FLAT;
    end

    // counter past a shortened frame counts as the frame's last sample
    last  = pos_ext >= (len_eff - CmpW'(1));
    pos_d = last ? '0 : pos_q + PosW'(1);

    finer     = cur_q_q > ovl_q_q;
    dq        = finer ? (cur_q_q - ovl_q_q) : (ovl_q_q - cur_q_q);
    neg_frame = ~in_data_i.frame_sample + DataW'(1);

    q_job_o.region    = region;
    q_job_o.op_a      = ((region == RGN_FALL) || (region == RGN_TAIL)) ?
                        neg_frame : in_data_i.frame_sample;
    q_job_o.ovl       = in_data_i.overlap_sample;
    q_job_o.fwd       = in_data_i.forward_coef;
    q_job_o.rev       = in_data_i.reverse_coef;
    q_job_o.cur_finer = finer;
    q_job_o.oq        = finer ? ovl_q_q : cur_q_q;
    q_job_o.frame_end = last;
    case (region)
      RGN_FLAT: q_job_o.sh = finer ? '0 : dq;
      RGN_TAIL: q_job_o.sh = finer ? dq : '0;
      default:  q_job_o.sh = dq;
    endcase
  end

  assign q_push_o = in_valid_i && q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (q_push_o) begin
      pos_q <= pos_d;
    end
  end

endmodule
`default_nettype wire

>>> src/lwoa_queue.sv
// Short queue of classified words between front and back.
`default_nettype none
module lwoa_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  wire lwoa_pkg::lwoa_job_t push_job_i,
  output logic                 ready_o,
  input  wire                  pop_i,
  output logic                 valid_o,
  output lwoa_pkg::lwoa_job_t  pop_job_o
);
  import lwoa_pkg::*;

  lwoa_job_t        mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_pop;

  assign ready_o   = cnt_q < QCntW'(QueueDepth);
  assign valid_o   = cnt_q != '0;
  assign pop_job_o = mem_q[rd_ptr_q];
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (do_pop && !push_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> src/lwoa_back.sv
// Back end: Q31 multiply stage, then align, add/saturate into the output register.
`default_nettype none
module lwoa_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  job_valid_i,
  input  wire lwoa_pkg::lwoa_job_t job_i,
  output logic                 job_pop_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output lwoa_pkg::lwoa_out_t  out_data_o
);
  import lwoa_pkg::*;

  logic                    s1_valid_q, s2_valid_q;
  logic                    s1_en, s2_en;
  lwoa_job_t               s1_job_q;
  logic signed [ProdW-1:0] s1_pa_q, s1_pb_q;
  lwoa_out_t               s2_q, s2_d;

  logic signed [DataW-1:0] a, b, sel, other, shifted;
  logic signed [DataW:0]   sum;
  logic                    trans;

  assign s2_en     = !s2_valid_q || out_ready_i;
  assign s1_en     = !s1_valid_q || s2_en;
  assign job_pop_o = s1_en && job_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= job_valid_i;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // signed 32x32 products with full 64-bit results
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      s1_job_q <= job_i;
      s1_pa_q  <= job_i.op_a * job_i.fwd;
      s1_pb_q  <= job_i.ovl * job_i.rev;
    end
    if (s2_en && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  always_comb begin
    // Q31 product: arithmetic shift by 31, keep the low word
    a     = s1_pa_q[QFrac+DataW-1:QFrac];
    b     = s1_pb_q[QFrac+DataW-1:QFrac];
    trans = (s1_job_q.region == RGN_RISE) || (s1_job_q.region == RGN_FALL);
    if (trans) begin
      sel   = s1_job_q.cur_finer ? a : b;
      other = s1_job_q.cur_finer ? b : a;
    end else begin
      sel   = (s1_job_q.region == RGN_FLAT) ? s1_job_q.ovl : s1_job_q.op_a;
      other = '0;
    end
    shifted = sel >>> s1_job_q.sh;
    sum     = (DataW+1)'(shifted) + (DataW+1)'(other);
    if (sum[DataW] != sum[DataW-1]) begin
      s2_d.out_sample = sum[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      s2_d.out_sample = sum[DataW-1:0];
    end
    s2_d.out_q     = s1_job_q.oq;
    s2_d.frame_end = s1_job_q.frame_end;
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_q;

endmodule
`default_nettype wire

>>> src/long_window_region_overlap_add_unit.sv
// Top level of the long-window region overlap-add unit.
//
// Usage:
//  - in channel (in_valid_i/in_ready_o/in_data_i): one word per sample position,
//    carrying frame sample, overlap sample and both window coefficients.
//  - out channel (out_valid_o/out_ready_i/out_data_o): one word per input word,
//    saturated sample, output Q and a frame-end flag on the frame's last sample.
//  - cfg channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i): always ready;
//    write only while no words are in flight.
//  - Path: an accepted word is written into the queue, popped into the
//    multiply stage, then held in the output register.
//  - Throughput: one word per cycle while out_ready_i is high.
//  - The front classifies into a two-word queue; when out_ready_i is low the
//    output register holds, the multiply stage and queue fill, and in_ready_o
//    drops once the queue is full. Nothing is dropped.
//  - Reset: config registers return to their defaults (frame length 1024),
//    the position counter goes to zero and queue and pipeline empty.
`default_nettype none
module long_window_region_overlap_add_unit (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire [lwoa_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire [lwoa_pkg::CfgW-1:0]    cfg_data_i,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire lwoa_pkg::lwoa_in_t     in_data_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output lwoa_pkg::lwoa_out_t         out_data_o
);
  import lwoa_pkg::*;

  logic      push, q_ready, q_valid, pop;
  lwoa_job_t push_job, pop_job;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = q_ready;

  lwoa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .q_ready_i   (q_ready),
    .q_push_o    (push),
    .q_job_o     (push_job)
  );

  lwoa_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .ready_o    (q_ready),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_job_o  (pop_job)
  );

  lwoa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (pop_job),
    .job_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
